// File: rtl/core/tpdq_pkg.sv
// Shared types, codes and default sizes of the typed priority dispatch queue.
// Used by tpdq_scan and typed_priority_dispatch_queue_unit.
// No dependencies.
package tpdq_pkg;

    // Default sizes.
    localparam int WORKERS_DEF = 4;
    localparam int SLOTS_DEF   = 64;
    localparam int MAX_RESULTS = 64;

    // Field widths.
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int REM_W   = 16;
    localparam int TYPE_W  = 4;
    localparam int LIMIT_W = 7;
    localparam int WI_W    = 2;
    localparam int CODE_W  = 4;
    localparam int NRES_W  = 7;

    // Commands.
    localparam logic [1:0] CMD_ADD        = 2'd0;
    localparam logic [1:0] CMD_QUERY_WKR  = 2'd1;
    localparam logic [1:0] CMD_QUERY_JOB  = 2'd2;
    localparam logic [1:0] CMD_LIST       = 2'd3;

    // Job status.
    localparam logic [1:0] ST_PENDING   = 2'd0;
    localparam logic [1:0] ST_RUNNING   = 2'd1;
    localparam logic [1:0] ST_DONE      = 2'd2;
    localparam logic [1:0] ST_DISCARDED = 2'd3;

    // Result codes.
    localparam logic [3:0] RC_ACCEPTED  = 4'd0;
    localparam logic [3:0] RC_DROPPED   = 4'd1;
    localparam logic [3:0] RC_FULL      = 4'd2;
    localparam logic [3:0] RC_RESTING   = 4'd3;
    localparam logic [3:0] RC_DOING     = 4'd4;
    localparam logic [3:0] RC_PENDING   = 4'd5;
    localparam logic [3:0] RC_UNKNOWN   = 4'd9;
    localparam logic [3:0] RC_FINISHED  = 4'd10;
    localparam logic [3:0] RC_EMPTY     = 4'd11;
    localparam logic [3:0] RC_NO_WORKER = 4'd12;

    // Configuration register indexes.
    localparam logic [2:0] REG_LIMIT  = 3'd0;
    localparam logic [2:0] REG_TYPE_0 = 3'd1;
    localparam logic [2:0] REG_TYPE_3 = 3'd4;

    // What a table scan looks for.
    typedef enum logic [1:0] {
        SCAN_PICK  = 2'd0,
        SCAN_EVICT = 2'd1,
        SCAN_FIND  = 2'd2
    } scan_mode_t;

    // Fixed part of a job table entry.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [REM_W-1:0]  rem;
        logic [TYPE_W-1:0] jtype;
    } entry_t;

    // Fields kept for the best entry of a scan.
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   id;
        logic [REM_W-1:0]  rem;
        logic [1:0]        status;
    } hit_t;

endpackage

// File: rtl/core/tpdq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tpdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/tpdq_scan.sv
// Shared compare unit: walks job table entries one per cycle and keeps the best one.
// Depends on tpdq_pkg.
module tpdq_scan #(
    parameter int IDX_W = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic                     cmp_valid,
    input  tpdq_pkg::scan_mode_t     mode,
    input  logic [IDX_W-1:0]         cmp_idx,
    input  tpdq_pkg::entry_t         ent,
    input  logic [1:0]               ent_status,
    input  logic [tpdq_pkg::TYPE_W-1:0] key_type,
    input  logic [tpdq_pkg::ID_W-1:0]   key_id,
    output tpdq_pkg::hit_t           hit,
    output logic [IDX_W-1:0]         hit_idx
);

    logic                          found_reg;
    logic [tpdq_pkg::PRIO_W-1:0]   prio_reg;
    logic [tpdq_pkg::ID_W-1:0]     id_reg;
    logic [tpdq_pkg::REM_W-1:0]    rem_reg;
    logic [1:0]                    status_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          take;

    // Selection rule of each scan kind; ties go to the later entry where priority decides.
    always_comb
    begin
        case (mode)
            tpdq_pkg::SCAN_PICK:
                take = (ent_status == tpdq_pkg::ST_PENDING) && (ent.jtype == key_type)
                    && (!found_reg || (ent.prio >= prio_reg));
            tpdq_pkg::SCAN_EVICT:
                take = (ent_status == tpdq_pkg::ST_PENDING)
                    && (!found_reg || (ent.prio <= prio_reg));
            tpdq_pkg::SCAN_FIND:
                take = !found_reg && (ent.id == key_id);
            default:
                take = 1'b0;
        endcase
    end

    // Found flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (cmp_valid && take)
        begin
            found_reg <= 1'b1;
        end
    end

    // Best entry payload.
    always_ff @(posedge clk)
    begin
        if (cmp_valid && take)
        begin
            prio_reg   <= ent.prio;
            id_reg     <= ent.id;
            rem_reg    <= ent.rem;
            status_reg <= ent_status;
            idx_reg    <= cmp_idx;
        end
    end

    assign hit.found  = found_reg;
    assign hit.id     = id_reg;
    assign hit.rem    = rem_reg;
    assign hit.status = status_reg;
    assign hit_idx    = idx_reg;

endmodule

// File: rtl/core/typed_priority_dispatch_queue_unit.sv
// Top level of the typed priority dispatch queue: sequencer, worker state and job tables.
// Depends on tpdq_pkg, tpdq_ram and tpdq_scan.
//
// Usage:
// Requests enter on the s_axis channel, one at a time: s_axis_tready is high only while
// the block is idle. Each request first advances every worker by one tick, then runs its
// command. Results leave on the m_axis channel; m_axis_tlast marks the final result of a
// request. A list request gives one result per finished job of the worker (at most 64),
// or a single empty result if there is none; every other request gives exactly one result.
// Configuration writes arrive on the cfg channel (cfg_ready is always high) and must be
// made only while the block is idle; the block itself does not enforce this.
// The tick visits each worker in turn and, for each idle worker, scans the job table
// for a job of its type. An add that must evict scans the table once more, a job query
// scans it once and a list reads the finish log entry by entry. All table scans go
// through one RAM read port and the shared compare unit.
// Reset empties the job table and the pool, idles every worker and restores the
// register defaults. A stalled receiver holds the result register; the sequencer waits
// until the result is taken, and the next request is accepted while the last result
// still waits.
module typed_priority_dispatch_queue_unit #(
    parameter int WORKERS     = tpdq_pkg::WORKERS_DEF,
    parameter int TABLE_SLOTS = tpdq_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], job_id[17:2], priority_req[25:18], duration[41:26],
    // job_type[45:42], worker_index[47:46]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_code[3:0], job_id_res[19:4], zero fill[23:20]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int WID_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int CMP_W = (CNT_W > tpdq_pkg::LIMIT_W) ? CNT_W : tpdq_pkg::LIMIT_W;
    localparam int LOG_W = tpdq_pkg::ID_W + WID_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_TCHK  = 12'b000000000010,
        S_TSCAN = 12'b000000000100,
        S_TPICK = 12'b000000001000,
        S_CMD   = 12'b000000010000,
        S_ESCAN = 12'b000000100000,
        S_EWR   = 12'b000001000000,
        S_FSCAN = 12'b000010000000,
        S_LRD   = 12'b000100000000,
        S_LCHK  = 12'b001000000000,
        S_LEND  = 12'b010000000000,
        S_RESP  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // Request fields.
    logic [1:0]                     cmd_reg;
    logic [tpdq_pkg::ID_W-1:0]      jid_reg;
    logic [tpdq_pkg::PRIO_W-1:0]    prio_reg;
    logic [tpdq_pkg::REM_W-1:0]     dur_reg;
    logic [tpdq_pkg::TYPE_W-1:0]    jtype_reg;
    logic [tpdq_pkg::WI_W-1:0]      wi_reg;

    // Configuration.
    logic [tpdq_pkg::LIMIT_W-1:0]   limit_reg;
    logic [tpdq_pkg::TYPE_W-1:0]    wtype_reg [4];

    // Counters and worker state.
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               wait_reg, wait_next;
    logic [CNT_W-1:0]               fc_reg, fc_next;
    logic                           run_valid_reg [WORKERS];
    logic                           run_valid_next [WORKERS];
    logic [IDX_W-1:0]               run_slot_reg [WORKERS];
    logic [IDX_W-1:0]               run_slot_next [WORKERS];
    logic [tpdq_pkg::REM_W-1:0]     run_rem_reg [WORKERS];
    logic [tpdq_pkg::REM_W-1:0]     run_rem_next [WORKERS];
    logic [tpdq_pkg::ID_W-1:0]      run_id_reg [WORKERS];
    logic [tpdq_pkg::ID_W-1:0]      run_id_next [WORKERS];
    logic [WID_W-1:0]               wk_reg, wk_next;

    // Scan sequencing.
    logic [CNT_W-1:0]               sidx_reg, sidx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                           scan_clear;
    logic                           scan_rd;
    logic                           scan_done;
    tpdq_pkg::scan_mode_t           scan_mode;
    tpdq_pkg::hit_t                 hit;
    logic [IDX_W-1:0]               hit_idx;

    // List walk.
    logic [CNT_W-1:0]               k_reg, k_next;
    logic [tpdq_pkg::NRES_W-1:0]    n_reg, n_next;
    logic                           held_reg, held_next;
    logic [tpdq_pkg::ID_W-1:0]      held_id_reg, held_id_next;

    // Final result of a request.
    logic [tpdq_pkg::CODE_W-1:0]    res_code_reg, res_code_next;
    logic [tpdq_pkg::ID_W-1:0]      res_id_reg, res_id_next;

    // Output register.
    logic                           out_valid_reg;
    logic [tpdq_pkg::CODE_W-1:0]    out_code_reg;
    logic [tpdq_pkg::ID_W-1:0]      out_id_reg;
    logic                           out_last_reg;
    logic                           out_free;
    logic                           out_load;
    logic [tpdq_pkg::CODE_W-1:0]    out_code_d;
    logic [tpdq_pkg::ID_W-1:0]      out_id_d;
    logic                           out_last_d;

    // Memory ports.
    logic                           stat_wr_en;
    logic [IDX_W-1:0]               stat_wr_addr;
    logic [1:0]                     stat_wr_data;
    logic [1:0]                     stat_rd;
    logic                           ent_wr_en;
    tpdq_pkg::entry_t               ent_wr_data;
    tpdq_pkg::entry_t               ent_rd;
    logic                           log_wr_en;
    logic [LOG_W-1:0]               log_wr_data;
    logic                           log_rd_en;
    logic [LOG_W-1:0]               log_rd;

    logic                           served;
    logic                           wi_ok;
    logic [WID_W-1:0]               qw;
    logic [tpdq_pkg::TYPE_W-1:0]    key_type;
    logic                           last_wk;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign key_type      = wtype_reg[2'(wk_reg)];
    assign last_wk       = (wk_reg == WID_W'(WORKERS - 1));
    assign wi_ok         = (int'(wi_reg) < WORKERS);
    assign qw            = WID_W'(wi_reg);
    assign scan_rd       = (sidx_reg < count_reg);
    assign scan_done     = !scan_rd && !cmp_valid_reg;

    // Is any worker serving the requested type.
    always_comb
    begin
        served = 1'b0;
        for (int w = 0; w < WORKERS; w++)
        begin
            if (wtype_reg[w % 4] == jtype_reg)
            begin
                served = 1'b1;
            end
        end
    end

    // Scan kind follows the scanning state.
    always_comb
    begin
        case (state_reg)
            S_ESCAN: scan_mode = tpdq_pkg::SCAN_EVICT;
            S_FSCAN: scan_mode = tpdq_pkg::SCAN_FIND;
            default: scan_mode = tpdq_pkg::SCAN_PICK;
        endcase
    end

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        fc_next        = fc_reg;
        wk_next        = wk_reg;
        sidx_next      = sidx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        scan_clear     = 1'b0;
        k_next         = k_reg;
        n_next         = n_reg;
        held_next      = held_reg;
        held_id_next   = held_id_reg;
        res_code_next  = res_code_reg;
        res_id_next    = res_id_reg;
        stat_wr_en     = 1'b0;
        stat_wr_addr   = hit_idx;
        stat_wr_data   = tpdq_pkg::ST_PENDING;
        ent_wr_en      = 1'b0;
        ent_wr_data    = '{id: jid_reg, prio: prio_reg, rem: dur_reg, jtype: jtype_reg};
        log_wr_en      = 1'b0;
        log_wr_data    = {run_id_reg[wk_reg], wk_reg};
        log_rd_en      = 1'b0;
        out_load       = 1'b0;
        out_code_d     = res_code_reg;
        out_id_d       = res_id_reg;
        out_last_d     = 1'b1;
        for (int w = 0; w < WORKERS; w++)
        begin
            run_valid_next[w] = run_valid_reg[w];
            run_slot_next[w]  = run_slot_reg[w];
            run_rem_next[w]   = run_rem_reg[w];
            run_id_next[w]    = run_id_reg[w];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    wk_next    = '0;
                    state_next = S_TCHK;
                end
            end

            // Worker tick: count down, finish, or look for a job.
            S_TCHK:
            begin
                if (run_valid_reg[wk_reg] && (run_rem_reg[wk_reg] != '0))
                begin
                    run_rem_next[wk_reg] = run_rem_reg[wk_reg] - 1'b1;
                    if (last_wk)
                    begin
                        state_next = S_CMD;
                    end
                    else
                    begin
                        wk_next = wk_reg + 1'b1;
                    end
                end
                else
                begin
                    if (run_valid_reg[wk_reg])
                    begin
                        stat_wr_en             = 1'b1;
                        stat_wr_addr           = run_slot_reg[wk_reg];
                        stat_wr_data           = tpdq_pkg::ST_DONE;
                        log_wr_en              = 1'b1;
                        fc_next                = fc_reg + 1'b1;
                        run_valid_next[wk_reg] = 1'b0;
                    end
                    scan_clear = 1'b1;
                    sidx_next  = '0;
                    state_next = S_TSCAN;
                end
            end

            S_TSCAN, S_ESCAN, S_FSCAN:
            begin
                if (scan_rd)
                begin
                    sidx_next      = sidx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = sidx_reg[IDX_W-1:0];
                end
                if (scan_done)
                begin
                    case (state_reg)
                        S_TSCAN:
                        begin
                            state_next = S_TPICK;
                        end
                        S_ESCAN:
                        begin
                            if (hit.found)
                            begin
                                stat_wr_en   = 1'b1;
                                stat_wr_data = tpdq_pkg::ST_DISCARDED;
                                wait_next    = wait_reg - 1'b1;
                            end
                            state_next = S_EWR;
                        end
                        default:
                        begin
                            res_id_next = jid_reg;
                            if (hit.found)
                            begin
                                res_code_next = tpdq_pkg::RC_PENDING + 4'(hit.status);
                            end
                            else
                            begin
                                res_code_next = tpdq_pkg::RC_UNKNOWN;
                            end
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Start the best job found and give it its first tick.
            S_TPICK:
            begin
                if (hit.found)
                begin
                    stat_wr_en             = 1'b1;
                    stat_wr_data           = tpdq_pkg::ST_RUNNING;
                    run_valid_next[wk_reg] = 1'b1;
                    run_slot_next[wk_reg]  = hit_idx;
                    run_id_next[wk_reg]    = hit.id;
                    run_rem_next[wk_reg]   = (hit.rem != '0) ? hit.rem - 1'b1 : hit.rem;
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                    end
                end
                if (last_wk)
                begin
                    state_next = S_CMD;
                end
                else
                begin
                    wk_next    = wk_reg + 1'b1;
                    state_next = S_TCHK;
                end
            end

            S_CMD:
            begin
                res_id_next = '0;
                scan_clear  = 1'b1;
                sidx_next   = '0;
                state_next  = S_RESP;
                case (cmd_reg)
                    tpdq_pkg::CMD_ADD:
                    begin
                        res_id_next = jid_reg;
                        if (!served)
                        begin
                            res_code_next = tpdq_pkg::RC_NO_WORKER;
                        end
                        else if (limit_reg == '0)
                        begin
                            res_code_next = tpdq_pkg::RC_DROPPED;
                        end
                        else if (count_reg == CNT_W'(TABLE_SLOTS))
                        begin
                            res_code_next = tpdq_pkg::RC_FULL;
                        end
                        else if (CMP_W'(wait_reg) >= CMP_W'(limit_reg))
                        begin
                            state_next = S_ESCAN;
                        end
                        else
                        begin
                            state_next = S_EWR;
                        end
                    end
                    tpdq_pkg::CMD_QUERY_JOB:
                    begin
                        state_next = S_FSCAN;
                    end
                    tpdq_pkg::CMD_QUERY_WKR:
                    begin
                        if (!wi_ok)
                        begin
                            res_code_next = tpdq_pkg::RC_NO_WORKER;
                        end
                        else if (run_valid_reg[qw])
                        begin
                            res_code_next = tpdq_pkg::RC_DOING;
                            res_id_next   = run_id_reg[qw];
                        end
                        else
                        begin
                            res_code_next = tpdq_pkg::RC_RESTING;
                        end
                    end
                    default:
                    begin
                        if (!wi_ok)
                        begin
                            res_code_next = tpdq_pkg::RC_NO_WORKER;
                        end
                        else
                        begin
                            k_next     = '0;
                            n_next     = '0;
                            held_next  = 1'b0;
                            state_next = S_LRD;
                        end
                    end
                endcase
            end

            // Record the new job as pending.
            S_EWR:
            begin
                ent_wr_en     = 1'b1;
                stat_wr_en    = 1'b1;
                stat_wr_addr  = count_reg[IDX_W-1:0];
                stat_wr_data  = tpdq_pkg::ST_PENDING;
                count_next    = count_reg + 1'b1;
                wait_next     = wait_reg + 1'b1;
                res_code_next = tpdq_pkg::RC_ACCEPTED;
                state_next    = S_RESP;
            end

            // Walk the finish log in finishing order.
            S_LRD:
            begin
                if ((k_reg < fc_reg) && (n_reg < tpdq_pkg::NRES_W'(tpdq_pkg::MAX_RESULTS)))
                begin
                    log_rd_en  = 1'b1;
                    state_next = S_LCHK;
                end
                else
                begin
                    state_next = S_LEND;
                end
            end

            // One result is held back so the final one can carry last.
            S_LCHK:
            begin
                if (4'(log_rd[WID_W-1:0]) == 4'(wi_reg))
                begin
                    if (!held_reg || out_free)
                    begin
                        if (held_reg)
                        begin
                            out_load   = 1'b1;
                            out_code_d = tpdq_pkg::RC_FINISHED;
                            out_id_d   = held_id_reg;
                            out_last_d = 1'b0;
                        end
                        held_next    = 1'b1;
                        held_id_next = log_rd[LOG_W-1:WID_W];
                        n_next       = n_reg + 1'b1;
                        k_next       = k_reg + 1'b1;
                        state_next   = S_LRD;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_LRD;
                end
            end

            S_LEND:
            begin
                if (held_reg)
                begin
                    res_code_next = tpdq_pkg::RC_FINISHED;
                    res_id_next   = held_id_reg;
                end
                else
                begin
                    res_code_next = tpdq_pkg::RC_EMPTY;
                    res_id_next   = '0;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            fc_reg        <= '0;
            wk_reg        <= '0;
            sidx_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            k_reg         <= '0;
            n_reg         <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < WORKERS; w++)
            begin
                run_valid_reg[w] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            fc_reg        <= fc_next;
            wk_reg        <= wk_next;
            sidx_reg      <= sidx_next;
            cmp_valid_reg <= cmp_valid_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            held_reg      <= held_next;
            for (int w = 0; w < WORKERS; w++)
            begin
                run_valid_reg[w] <= run_valid_next[w];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tpdq_pkg::LIMIT_W'(TABLE_SLOTS > 64 ? 64 : 64);
            for (int i = 0; i < 4; i++)
            begin
                wtype_reg[i] <= tpdq_pkg::TYPE_W'(i);
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tpdq_pkg::REG_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
            else if ((cfg_index >= tpdq_pkg::REG_TYPE_0) && (cfg_index <= tpdq_pkg::REG_TYPE_3))
            begin
                wtype_reg[2'(cfg_index - tpdq_pkg::REG_TYPE_0)] <= cfg_data[3:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= s_axis_tdata[1:0];
            jid_reg   <= s_axis_tdata[17:2];
            prio_reg  <= s_axis_tdata[25:18];
            dur_reg   <= s_axis_tdata[41:26];
            jtype_reg <= s_axis_tdata[45:42];
            wi_reg    <= s_axis_tdata[47:46];
        end
        cmp_idx_reg   <= cmp_idx_next;
        held_id_reg   <= held_id_next;
        res_code_reg  <= res_code_next;
        res_id_reg    <= res_id_next;
        for (int w = 0; w < WORKERS; w++)
        begin
            run_slot_reg[w] <= run_slot_next[w];
            run_rem_reg[w]  <= run_rem_next[w];
            run_id_reg[w]   <= run_id_next[w];
        end
        if (out_load)
        begin
            out_code_reg <= out_code_d;
            out_id_reg   <= out_id_d;
            out_last_reg <= out_last_d;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_id_reg, out_code_reg};
    assign m_axis_tlast  = out_last_reg;

    // Fixed entry fields.
    tpdq_ram #(
        .WIDTH ($bits(tpdq_pkg::entry_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (ent_wr_data),
        .rd_en   (scan_rd),
        .rd_addr (sidx_reg[IDX_W-1:0]),
        .rd_data (ent_rd)
    );

    // Entry status.
    tpdq_ram #(
        .WIDTH (2),
        .DEPTH (TABLE_SLOTS)
    ) u_status_ram (
        .clk     (clk),
        .wr_en   (stat_wr_en),
        .wr_addr (stat_wr_addr),
        .wr_data (stat_wr_data),
        .rd_en   (scan_rd),
        .rd_addr (sidx_reg[IDX_W-1:0]),
        .rd_data (stat_rd)
    );

    // Finished jobs in finishing order, with the worker that ran them.
    tpdq_ram #(
        .WIDTH (LOG_W),
        .DEPTH (TABLE_SLOTS)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (log_wr_en),
        .wr_addr (fc_reg[IDX_W-1:0]),
        .wr_data (log_wr_data),
        .rd_en   (log_rd_en),
        .rd_addr (k_reg[IDX_W-1:0]),
        .rd_data (log_rd)
    );

    // Shared compare unit for every table scan.
    tpdq_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .cmp_valid  (cmp_valid_reg),
        .mode       (scan_mode),
        .cmp_idx    (cmp_idx_reg),
        .ent        (ent_rd),
        .ent_status (stat_rd),
        .key_type   (key_type),
        .key_id     (jid_reg),
        .hit        (hit),
        .hit_idx    (hit_idx)
    );

    // The pool never holds more jobs than the table.
    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg <= count_reg)
        else $error("waiting count above entry count");

    // Every finished job is a table entry.
    a_finish_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= count_reg)
        else $error("finish count above entry count");

    // An accepted request always starts with the worker tick.
    a_start_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_TCHK))
        else $error("request did not start a tick");

    // A result is loaded only when the output register is free.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrote a waiting result");

endmodule
